>>> src/afct_pkg.sv
// shared constants, types and request codes for the aabb frustum cull test
// used by every module of the block; depends on nothing
package afct_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  localparam int MAT_ENTRIES = 16;
  localparam int STORE_DEPTH = MAT_ENTRIES + 4 * NUM_PLANES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PLANE_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int ACC_W       = PROD_W + 2;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  localparam logic signed [COORD_WIDTH-1:0] ONE_FX = COORD_WIDTH'(1) << FRAC_BITS;

  // one multiply-accumulate op as seen by the shared unit
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       dot;
    logic [1:0] row;
  } mac_op_t;

  // finished four-term sum
  typedef struct packed {
    logic       valid;
    logic       dot;
    logic [1:0] row;
  } mac_done_t;

endpackage

>>> src/aabb_frustum_cull_test_top.sv
// aabb frustum cull test top: coefficient loads give no result
// box test: walks the planes in order and returns one culled flag
// the walk stops at the first plane that culls; one shared 32x32 mac does all products
// in_tready is low while a box test runs; one finished result may wait in the output register
// synchronous active-low reset clears the control state and marks the whole store zero
// depends on afct_pkg, afct_coef_store, afct_mac, afct_seq
module aabb_frustum_cull_test_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coeff_index, coeff_value, min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  logic [afct_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // culled, zero pad
  output logic [afct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic signed [afct_pkg::COORD_WIDTH-1:0] box_min [3];
  logic signed [afct_pkg::COORD_WIDTH-1:0] box_max [3];
  logic                                    mem_we;
  logic [afct_pkg::ADDR_W-1:0]             mem_wa;
  logic [afct_pkg::COORD_WIDTH-1:0]        mem_wd;
  logic [afct_pkg::ADDR_W-1:0]             mem_ra;
  logic signed [afct_pkg::COORD_WIDTH-1:0] mem_rd;
  afct_pkg::mac_op_t                       mac_op;
  logic signed [afct_pkg::COORD_WIDTH-1:0] mac_a;
  logic signed [afct_pkg::COORD_WIDTH-1:0] mac_b;
  afct_pkg::mac_done_t                     mac_done;
  logic signed [afct_pkg::ACC_W-1:0]       mac_acc;
  logic                                    culled;

  assign box_min[0] = $signed(in_tdata[69:38]);
  assign box_min[1] = $signed(in_tdata[101:70]);
  assign box_min[2] = $signed(in_tdata[133:102]);
  assign box_max[0] = $signed(in_tdata[165:134]);
  assign box_max[1] = $signed(in_tdata[197:166]);
  assign box_max[2] = $signed(in_tdata[229:198]);

  afct_coef_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  afct_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  afct_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (in_tuser),
    .coeff_index (in_tdata[5:0]),
    .coeff_value ($signed(in_tdata[37:6])),
    .box_min     (box_min),
    .box_max     (box_max),
    .mem_we      (mem_we),
    .mem_wa      (mem_wa),
    .mem_wd      (mem_wd),
    .mem_ra      (mem_ra),
    .mem_rd      (mem_rd),
    .mac_op      (mac_op),
    .mac_a       (mac_a),
    .mac_b       (mac_b),
    .mac_done    (mac_done),
    .mac_acc     (mac_acc),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_culled  (culled)
  );

  assign out_tdata = {{(afct_pkg::OUT_TDATA_W-1){1'b0}}, culled};

  // a result only appears as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while a box test is still running");

  // a coefficient load never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == afct_pkg::REQ_LOAD) |=> !$rose(out_tvalid))
    else $error("coefficient load produced a result");

  // a box test holds off the input channel
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == afct_pkg::REQ_TEST) |=> !in_tready)
    else $error("input accepted during a box test");

  // the shared mac only finishes sums during a box test
  a_mac_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done.valid |-> !in_tready)
    else $error("mac finished a sum while idle");

endmodule

>>> src/afct_coef_store.sv
// coefficient store: matrix and plane equations, one write and one read port
// entries read as zero until written; uses afct_pkg
module afct_coef_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [afct_pkg::ADDR_W-1:0]           wr_addr,
  input  logic [afct_pkg::COORD_WIDTH-1:0]      wr_data,
  input  logic [afct_pkg::ADDR_W-1:0]           rd_addr,
  output logic signed [afct_pkg::COORD_WIDTH-1:0] rd_data
);

  logic [afct_pkg::COORD_WIDTH-1:0] mem_r [afct_pkg::STORE_DEPTH];
  logic [afct_pkg::STORE_DEPTH-1:0] valid_r;
  logic [afct_pkg::COORD_WIDTH-1:0] mem_q_r;
  logic                             vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    mem_q_r <= mem_r[rd_addr];
    vld_q_r <= valid_r[rd_addr];
  end

  assign rd_data = vld_q_r ? $signed(mem_q_r) : '0;

endmodule

>>> src/afct_mac.sv
// shared multiply-accumulate unit: registered 32x32 product, exact accumulator
// uses afct_pkg types
module afct_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  afct_pkg::mac_op_t                       op_i,
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] a_i,
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] b_i,
  output afct_pkg::mac_done_t                     done_o,
  output logic signed [afct_pkg::ACC_W-1:0]       acc_o
);

  logic signed [afct_pkg::PROD_W-1:0] prod_r;
  afct_pkg::mac_op_t                  op2_r;
  logic signed [afct_pkg::ACC_W-1:0]  acc_r;
  logic signed [afct_pkg::ACC_W-1:0]  acc_nxt;
  afct_pkg::mac_done_t                done_r;

  always_comb begin
    acc_nxt = (op2_r.first ? '0 : acc_r) + afct_pkg::ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op2_r  <= '0;
      done_r <= '0;
    end else begin
      op2_r        <= op_i;
      done_r.valid <= op2_r.valid & op2_r.last;
      done_r.dot   <= op2_r.dot;
      done_r.row   <= op2_r.row;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (op2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign done_o = done_r;
  assign acc_o  = acc_r;

endmodule

>>> src/afct_seq.sv
// sequencer: walks planes, feeds the shared mac, holds box, plane and vertex regs
// uses afct_pkg; drives afct_coef_store and afct_mac
module afct_seq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    req_type,
  input  logic [afct_pkg::IDX_W-1:0]              coeff_index,
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] coeff_value,
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] box_min [3],
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] box_max [3],
  output logic                                    mem_we,
  output logic [afct_pkg::ADDR_W-1:0]             mem_wa,
  output logic [afct_pkg::COORD_WIDTH-1:0]        mem_wd,
  output logic [afct_pkg::ADDR_W-1:0]             mem_ra,
  input  logic signed [afct_pkg::COORD_WIDTH-1:0] mem_rd,
  output afct_pkg::mac_op_t                       mac_op,
  output logic signed [afct_pkg::COORD_WIDTH-1:0] mac_a,
  output logic signed [afct_pkg::COORD_WIDTH-1:0] mac_b,
  input  afct_pkg::mac_done_t                     mac_done,
  input  logic signed [afct_pkg::ACC_W-1:0]       mac_acc,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_culled
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_XFORM = 6'b000100,
    ST_DOT   = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  localparam int HI_W = afct_pkg::ACC_W - afct_pkg::FRAC_BITS - afct_pkg::COORD_WIDTH + 1;
  localparam logic signed [afct_pkg::COORD_WIDTH-1:0] SAT_MAX =
    {1'b0, {(afct_pkg::COORD_WIDTH-1){1'b1}}};
  localparam logic signed [afct_pkg::COORD_WIDTH-1:0] SAT_MIN =
    {1'b1, {(afct_pkg::COORD_WIDTH-1){1'b0}}};

  function automatic logic signed [afct_pkg::COORD_WIDTH-1:0] sat_shift(
    input logic signed [afct_pkg::ACC_W-1:0] acc
  );
    logic [HI_W-1:0] hi;
    hi = acc[afct_pkg::ACC_W-1 -: HI_W];
    if (hi == '0 || hi == '1) begin
      return acc[afct_pkg::FRAC_BITS +: afct_pkg::COORD_WIDTH];
    end else if (acc[afct_pkg::ACC_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  state_t                        state_r, state_nxt;
  logic [3:0]                    step_r, step_nxt;
  logic [afct_pkg::PLANE_W-1:0]  plane_r, plane_nxt;
  logic                          res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_culled_r, out_culled_nxt;

  logic signed [afct_pkg::COORD_WIDTH-1:0] bmin_r [3];
  logic signed [afct_pkg::COORD_WIDTH-1:0] bmax_r [3];
  logic signed [afct_pkg::COORD_WIDTH-1:0] pl_r [4];
  logic signed [afct_pkg::COORD_WIDTH-1:0] tv_r [4];

  logic              iss_vld, iss_load;
  afct_pkg::mac_op_t iss_op;
  logic              s1_vld_r, s1_load_r;
  afct_pkg::mac_op_t s1_op_r;
  logic [1:0]        s1_k_r;
  logic              box_take;
  logic signed [afct_pkg::COORD_WIDTH-1:0] vtx;

  assign in_ready = (state_r == ST_IDLE);
  assign box_take = in_valid && in_ready && (req_type == afct_pkg::REQ_TEST);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    plane_nxt      = plane_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_culled_nxt = out_culled_r;
    iss_vld        = 1'b0;
    iss_load       = 1'b0;
    iss_op         = '0;
    mem_ra         = '0;
    mem_we         = 1'b0;
    mem_wa         = afct_pkg::ADDR_W'(coeff_index);
    mem_wd         = coeff_value;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == afct_pkg::REQ_TEST) begin
            state_nxt = ST_LOAD;
            step_nxt  = '0;
            plane_nxt = '0;
          end else if (coeff_index < afct_pkg::IDX_W'(afct_pkg::STORE_DEPTH)) begin
            mem_we = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        mem_ra   = afct_pkg::ADDR_W'(afct_pkg::MAT_ENTRIES)
                 + afct_pkg::ADDR_W'({plane_r, step_r[1:0]});
        iss_vld  = 1'b1;
        iss_load = 1'b1;
        step_nxt = step_r + 4'd1;
        if (step_r[1:0] == 2'd3) begin
          state_nxt = ST_XFORM;
          step_nxt  = '0;
        end
      end
      ST_XFORM: begin
        mem_ra       = afct_pkg::ADDR_W'(step_r);
        iss_vld      = 1'b1;
        iss_op.valid = 1'b1;
        iss_op.first = (step_r[1:0] == 2'd0);
        iss_op.last  = (step_r[1:0] == 2'd3);
        iss_op.row   = step_r[3:2];
        step_nxt     = step_r + 4'd1;
        if (step_r == 4'd15) begin
          state_nxt = ST_DOT;
          step_nxt  = '0;
        end
      end
      ST_DOT: begin
        iss_vld      = 1'b1;
        iss_op.valid = 1'b1;
        iss_op.dot   = 1'b1;
        iss_op.first = (step_r[1:0] == 2'd0);
        iss_op.last  = (step_r[1:0] == 2'd3);
        step_nxt     = step_r + 4'd1;
        if (step_r[1:0] == 2'd3) begin
          state_nxt = ST_WAIT;
          step_nxt  = '0;
        end
      end
      ST_WAIT: begin
        if (mac_done.valid && mac_done.dot) begin
          if (mac_acc[afct_pkg::ACC_W-1] ||
              plane_r == afct_pkg::PLANE_W'(afct_pkg::NUM_PLANES - 1)) begin
            res_nxt   = mac_acc[afct_pkg::ACC_W-1];
            state_nxt = ST_FIN;
          end else begin
            plane_nxt = plane_r + 1'b1;
            step_nxt  = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_culled_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operand select in the stage where store read data arrives
  always_comb begin
    if (s1_k_r == 2'd3) begin
      vtx = afct_pkg::ONE_FX;
    end else if (pl_r[s1_k_r][afct_pkg::COORD_WIDTH-1]) begin
      vtx = bmin_r[s1_k_r];
    end else begin
      vtx = bmax_r[s1_k_r];
    end
    mac_op       = s1_op_r;
    mac_op.valid = s1_vld_r & ~s1_load_r & s1_op_r.valid;
    mac_a        = s1_op_r.dot ? pl_r[s1_k_r] : mem_rd;
    mac_b        = s1_op_r.dot ? tv_r[s1_k_r] : vtx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s1_vld_r    <= iss_vld;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    plane_r      <= plane_nxt;
    res_r        <= res_nxt;
    out_culled_r <= out_culled_nxt;
    s1_load_r    <= iss_load;
    s1_op_r      <= iss_op;
    s1_k_r       <= step_r[1:0];
    if (box_take) begin
      bmin_r <= box_min;
      bmax_r <= box_max;
    end
    if (s1_vld_r && s1_load_r) begin
      pl_r[s1_k_r] <= mem_rd;
    end
    if (mac_done.valid && !mac_done.dot) begin
      tv_r[mac_done.row] <= sat_shift(mac_acc);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_culled = out_culled_r;

endmodule
